/* rtl/core/bcomp_pkg.sv */
`timescale 1ns / 1ps

package bcomp_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [15:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [17:0]        pressure_pa;
        logic               math_fault;
    } t_out_item;

    typedef enum logic [1:0] {
        CFG_CAL_A = 2'd0,
        CFG_CAL_B = 2'd1,
        CFG_CAL_C = 2'd2
    } t_cfg_index;

    localparam int CFG_DATA_W  = 64;
    localparam int CAL_C_W     = 48;

    localparam int C_B6_OFS    = 4000;
    localparam int C_P_QUAD    = 3038;
    localparam int C_P_LIN     = -7357;
    localparam int C_P_OFS     = 3791;
    localparam int C_B7_MUL    = 50000;
    localparam int C_B4_OFS    = 32768;
    localparam int C_PRESS_MAX = 262143;

    // temperature divide: |MC*2048| over |X1+MD|
    localparam int DIV1_NUM_W  = 27;
    localparam int DIV1_DEN_W  = 20;
    localparam int DIV1_SIDE_W = 37;
    // pressure divide: B7 (pre-scaled) over B4
    localparam int DIV2_W      = 33;
    localparam int DIV2_SIDE_W = 18;

endpackage

/* rtl/core/bcomp_udiv.sv */
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per register stage.
module bcomp_udiv
    import bcomp_pkg::*;
#(
    parameter int NUM_W  = 27,
    parameter int DEN_W  = 20,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic [NUM_W-1:0]  r_valid;

    for (genvar gk = 0; gk < NUM_W; gk++) begin : g_stage
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              fits;

        if (gk == 0) begin : g_first
            assign num_in  = i_num;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign num_in  = r_num[gk-1];
            assign rem_in  = r_rem[gk-1];
            assign den_in  = r_den[gk-1];
            assign side_in = r_side[gk-1];
            assign vld_in  = r_valid[gk-1];
        end

        // shift in the next dividend bit; quotient bits fill the freed low end
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gk] <= 1'b0;
            end else if (i_en) begin
                r_valid[gk] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[gk]  <= {num_in[NUM_W-2:0], fits};
                r_rem[gk]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[gk]  <= den_in;
                r_side[gk] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NUM_W-1];
    assign o_quo   = r_num[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

/* rtl/core/barometer_raw_compensation_core.sv */
`timescale 1ns / 1ps

// Barometric sensor compensation: takes a raw temperature / raw pressure pair and returns
// temperature in 0.1 C and pressure in Pa using the stock integer formulas with the
// calibration words written through the config port. Fully pipelined with 70 register stages
// from input to output: one item per cycle while the output is not held; the two pipelined
// dividers (27 stages for the temperature term, 33 stages for pressure) make up most of those
// stages. When the output is held the whole pipe freezes. math_fault flags a zero divisor
// (X1+MD or B4) and forces pressure to 0.
// Calibration words may only change while no item is in flight.
module barometer_raw_compensation_core
    import bcomp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_cal_a;
    logic [CFG_DATA_W-1:0] r_cal_b;
    logic [CAL_C_W-1:0]    r_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAL_A: r_cal_a <= i_cfg_wdata;
                CFG_CAL_B: r_cal_b <= i_cfg_wdata;
                CFG_CAL_C: r_cal_c <= i_cfg_wdata[CAL_C_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(r_cal_a[63:48]);
    assign ac2 = $signed(r_cal_a[47:32]);
    assign ac3 = $signed(r_cal_a[31:16]);
    assign ac4 = r_cal_a[15:0];
    assign ac5 = r_cal_b[63:48];
    assign ac6 = r_cal_b[47:32];
    assign b1  = $signed(r_cal_b[31:16]);
    assign b2  = $signed(r_cal_b[15:0]);
    assign mc  = $signed(r_cal_c[31:16]);
    assign md  = $signed(r_cal_c[15:0]);

    logic w_en;
    logic r_out_valid;
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // ---- S1: X1 = ((UT - AC6) * AC5) >>> 15
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_m;
    logic               r_s1_valid;
    logic signed [18:0] r_s1_x1;
    logic [15:0]        r_s1_up;

    assign s1_d = $signed({1'b0, i_in.raw_temperature}) - $signed({1'b0, ac6});
    assign s1_m = s1_d * $signed({1'b0, ac5});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x1 <= $signed(s1_m[33:15]);
            r_s1_up <= i_in.raw_pressure;
        end
    end

    // ---- temperature divide on magnitudes
    logic signed [19:0]      s2_den;
    logic signed [26:0]      s2_num;
    logic [DIV1_NUM_W-1:0]   s2_num_mag;
    logic [DIV1_DEN_W-1:0]   s2_den_mag;
    logic                    s2_qneg;
    logic                    s2_fault;
    logic [DIV1_SIDE_W-1:0]  s2_side;
    logic                    d1_valid;
    logic [DIV1_NUM_W-1:0]   d1_quo;
    logic [DIV1_SIDE_W-1:0]  d1_side;

    assign s2_den     = {r_s1_x1[18], r_s1_x1} + {{4{md[15]}}, md};
    assign s2_num     = {mc, 11'b0};
    assign s2_num_mag = s2_num[26] ? DIV1_NUM_W'(-s2_num) : DIV1_NUM_W'(s2_num);
    assign s2_den_mag = s2_den[19] ? DIV1_DEN_W'(-s2_den) : DIV1_DEN_W'(s2_den);
    assign s2_qneg    = mc[15] ^ s2_den[19];
    assign s2_fault   = (s2_den == '0);
    assign s2_side    = {r_s1_x1, r_s1_up, s2_fault, s2_qneg};

    bcomp_udiv #(
        .NUM_W  (DIV1_NUM_W),
        .DEN_W  (DIV1_DEN_W),
        .SIDE_W (DIV1_SIDE_W)
    ) u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_valid),
        .i_num   (s2_num_mag),
        .i_den   (s2_den_mag),
        .i_side  (s2_side),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // ---- S3: B5, temperature, B6
    logic signed [18:0] s3_x1;
    logic [15:0]        s3_up;
    logic               s3_fault;
    logic               s3_qneg;
    logic signed [27:0] s3_x2;
    logic signed [27:0] s3_b5;
    logic signed [27:0] s3_tsum;
    logic signed [23:0] s3_tsh;
    logic signed [15:0] s3_t;
    logic               r_s3_valid;
    logic signed [15:0] r_s3_t;
    logic signed [27:0] r_s3_b6;
    logic [15:0]        r_s3_up;
    logic               r_s3_fault;

    assign {s3_x1, s3_up, s3_fault, s3_qneg} = d1_side;

    always_comb begin
        if (s3_fault) begin
            s3_x2 = '0;
        end else if (s3_qneg) begin
            s3_x2 = -$signed({1'b0, d1_quo});
        end else begin
            s3_x2 = $signed({1'b0, d1_quo});
        end
        s3_b5   = {{9{s3_x1[18]}}, s3_x1} + s3_x2;
        s3_tsum = s3_b5 + 28'sd8;
        s3_tsh  = $signed(s3_tsum[27:4]);
        if (s3_tsh < -24'sd32768) begin
            s3_t = -16'sd32768;
        end else if (s3_tsh > 24'sd32767) begin
            s3_t = 16'sd32767;
        end else begin
            s3_t = s3_tsh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_t     <= s3_t;
            r_s3_b6    <= s3_b5 - 28'(C_B6_OFS);
            r_s3_up    <= s3_up;
            r_s3_fault <= s3_fault;
        end
    end

    // ---- S4: B6^2, AC2*B6, AC3*B6
    logic               r_s4_valid;
    logic signed [55:0] r_s4_sq;
    logic signed [43:0] r_s4_pac2;
    logic signed [43:0] r_s4_pac3;
    logic signed [15:0] r_s4_t;
    logic [15:0]        r_s4_up;
    logic               r_s4_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_sq    <= r_s3_b6 * r_s3_b6;
            r_s4_pac2  <= ac2 * r_s3_b6;
            r_s4_pac3  <= ac3 * r_s3_b6;
            r_s4_t     <= r_s3_t;
            r_s4_up    <= r_s3_up;
            r_s4_fault <= r_s3_fault;
        end
    end

    // ---- S5: B2*B6SQ, B1*B6SQ
    logic signed [43:0] s5_b6sq;
    logic               r_s5_valid;
    logic signed [59:0] r_s5_pb2;
    logic signed [59:0] r_s5_pb1;
    logic signed [32:0] r_s5_pac2s;
    logic signed [30:0] r_s5_pac3s;
    logic signed [15:0] r_s5_t;
    logic [15:0]        r_s5_up;
    logic               r_s5_fault;

    assign s5_b6sq = $signed(r_s4_sq[55:12]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_pb2   <= b2 * s5_b6sq;
            r_s5_pb1   <= b1 * s5_b6sq;
            r_s5_pac2s <= $signed(r_s4_pac2[43:11]);
            r_s5_pac3s <= $signed(r_s4_pac3[43:13]);
            r_s5_t     <= r_s4_t;
            r_s5_up    <= r_s4_up;
            r_s5_fault <= r_s4_fault;
        end
    end

    // ---- S6: B3 and X3+32768, kept modulo 2^32 (only the low word reaches B4 and B7)
    logic [33:0] s6_b3_sum;
    logic [33:0] s6_x3_sum;
    logic [31:0] s6_x3;
    logic        r_s6_valid;
    logic [31:0] r_s6_b3lo;
    logic [31:0] r_s6_xs;
    logic signed [15:0] r_s6_t;
    logic [15:0] r_s6_up;
    logic        r_s6_fault;

    assign s6_b3_sum = {{16{ac1[15]}}, ac1, 2'b0} + r_s5_pb2[44:11]
                     + {r_s5_pac2s[32], r_s5_pac2s} + 34'd2;
    assign s6_x3_sum = r_s5_pb1[49:16] + {{3{r_s5_pac3s[30]}}, r_s5_pac3s} + 34'd2;
    assign s6_x3     = s6_x3_sum[33:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_b3lo  <= s6_b3_sum[33:2];
            r_s6_xs    <= s6_x3 + 32'(C_B4_OFS);
            r_s6_t     <= r_s5_t;
            r_s6_up    <= r_s5_up;
            r_s6_fault <= r_s5_fault;
        end
    end

    // ---- S7: B4 = (AC4 * X3s) >> 15, UP - B3
    logic [47:0] s7_prod;
    logic        r_s7_valid;
    logic [32:0] r_s7_b4;
    logic [31:0] r_s7_dlo;
    logic signed [15:0] r_s7_t;
    logic        r_s7_fault;

    assign s7_prod = ac4 * r_s6_xs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_b4    <= s7_prod[47:15];
            r_s7_dlo   <= {16'b0, r_s6_up} - r_s6_b3lo;
            r_s7_t     <= r_s6_t;
            r_s7_fault <= r_s6_fault;
        end
    end

    // ---- S8: B7
    logic [47:0] s8_prod;
    logic        r_s8_valid;
    logic [31:0] r_s8_b7;
    logic [32:0] r_s8_b4;
    logic signed [15:0] r_s8_t;
    logic        r_s8_fault;

    assign s8_prod = r_s7_dlo * 16'(C_B7_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_valid <= 1'b0;
        end else if (w_en) begin
            r_s8_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_b7    <= s8_prod[31:0];
            r_s8_b4    <= r_s7_b4;
            r_s8_t     <= r_s7_t;
            r_s8_fault <= r_s7_fault || (r_s7_b4 == '0);
        end
    end

    // ---- pressure divide: (B7*2)/B4 below the midpoint, else (B7/B4)*2
    logic                   s8_hi;
    logic [DIV2_W-1:0]      s8_num;
    logic [DIV2_SIDE_W-1:0] s8_side;
    logic                   d2_valid;
    logic [DIV2_W-1:0]      d2_quo;
    logic [DIV2_SIDE_W-1:0] d2_side;

    assign s8_hi   = r_s8_b7[31];
    assign s8_num  = s8_hi ? {1'b0, r_s8_b7} : {r_s8_b7, 1'b0};
    assign s8_side = {r_s8_t, r_s8_fault, s8_hi};

    bcomp_udiv #(
        .NUM_W  (DIV2_W),
        .DEN_W  (DIV2_W),
        .SIDE_W (DIV2_SIDE_W)
    ) u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s8_valid),
        .i_num   (s8_num),
        .i_den   (r_s8_b4),
        .i_side  (s8_side),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // ---- S9: p, (p>>8)^2
    logic signed [15:0] s9_t;
    logic               s9_fault;
    logic               s9_hi;
    logic [33:0]        s9_p;
    logic [25:0]        s9_q;
    logic               r_s9_valid;
    logic [51:0]        r_s9_qq;
    logic [33:0]        r_s9_p;
    logic signed [15:0] r_s9_t;
    logic               r_s9_fault;

    assign {s9_t, s9_fault, s9_hi} = d2_side;
    assign s9_p = s9_hi ? {d2_quo, 1'b0} : {1'b0, d2_quo};
    assign s9_q = s9_p[33:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (w_en) begin
            r_s9_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_qq    <= s9_q * s9_q;
            r_s9_p     <= s9_p;
            r_s9_t     <= s9_t;
            r_s9_fault <= s9_fault;
        end
    end

    // ---- S10: quadratic and linear correction terms
    logic [63:0]        s10_m1;
    logic signed [48:0] s10_m2;
    logic               r_s10_valid;
    logic [47:0]        r_s10_x1;
    logic signed [32:0] r_s10_x2;
    logic [33:0]        r_s10_p;
    logic signed [15:0] r_s10_t;
    logic               r_s10_fault;

    assign s10_m1 = r_s9_qq * 12'(C_P_QUAD);
    assign s10_m2 = $signed({1'b0, r_s9_p}) * 15'(C_P_LIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_valid <= 1'b0;
        end else if (w_en) begin
            r_s10_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_x1    <= s10_m1[63:16];
            r_s10_x2    <= $signed(s10_m2[48:16]);
            r_s10_p     <= r_s9_p;
            r_s10_t     <= r_s9_t;
            r_s10_fault <= r_s9_fault;
        end
    end

    // ---- S11: final pressure, saturate, output register
    logic signed [49:0] s11_sum;
    logic signed [45:0] s11_corr;
    logic signed [49:0] s11_pr;
    logic [17:0]        s11_press;
    t_out_item          r_out;

    always_comb begin
        s11_sum  = $signed({2'b0, r_s10_x1}) + {{17{r_s10_x2[32]}}, r_s10_x2}
                 + 50'(C_P_OFS);
        s11_corr = $signed(s11_sum[49:4]);
        s11_pr   = $signed({16'b0, r_s10_p}) + {{4{s11_corr[45]}}, s11_corr};
        if (r_s10_fault || s11_pr < 50'sd0) begin
            s11_press = '0;
        end else if (s11_pr > 50'(C_PRESS_MAX)) begin
            s11_press = 18'(C_PRESS_MAX);
        end else begin
            s11_press = s11_pr[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.temperature_tenths <= r_s10_t;
            r_out.pressure_pa        <= s11_press;
            r_out.math_fault         <= r_s10_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fault_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.math_fault |-> o_out.pressure_pa == '0)
        else $error("pressure nonzero on a faulted item");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted item missing from first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_s8_valid) && $stable(r_s3_valid))
        else $error("pipeline moved during stall");

endmodule

/* tb/barometer_raw_compensation_core_test.sv */
`timescale 1ns / 1ps

module barometer_raw_compensation_core_test;
    import bcomp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    barometer_raw_compensation_core DUT (.*);

    // calibration shadow
    logic [63:0] cal_a, cal_b, cal_c;

    t_in_item  pending_items[$];
    t_out_item expected_readings[$];
    int        error_count;
    int        idle_cycles;
    bit        calm_mode;
    bit        timed_out;
    logic      o_in_ready_q;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint sra(longint x, int n);
        return x >>> n;
    endfunction

    function automatic t_out_item compensate(t_in_item it);
        t_out_item r;
        longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        longint x1, x2, x3, b5, b6, b6sq, b3, t, pr, ps, q;
        longint unsigned b4, b7, p, sum32;
        bit fault;
        ac1 = longint'($signed(cal_a[63:48]));
        ac2 = longint'($signed(cal_a[47:32]));
        ac3 = longint'($signed(cal_a[31:16]));
        ac4 = longint'({1'b0, cal_a[15:0]});
        ac5 = longint'({1'b0, cal_b[63:48]});
        ac6 = longint'({1'b0, cal_b[47:32]});
        b1  = longint'($signed(cal_b[31:16]));
        b2  = longint'($signed(cal_b[15:0]));
        mc  = longint'($signed(cal_c[31:16]));
        md  = longint'($signed(cal_c[15:0]));
        ut  = longint'({1'b0, it.raw_temperature});
        up  = longint'({1'b0, it.raw_pressure});
        fault = 1'b0;
        x1 = sra((ut - ac6) * ac5, 15);
        if (x1 + md == 0) begin
            fault = 1'b1;
            x2 = 0;
        end else begin
            x2 = (mc * 2048) / (x1 + md);
        end
        b5 = x1 + x2;
        t = sra(b5 + 8, 4);
        if (t < -32768) t = -32768;
        if (t > 32767) t = 32767;
        b6 = b5 - C_B6_OFS;
        b6sq = sra(b6 * b6, 12);
        x1 = sra(b2 * b6sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(ac1 * 4 + x3 + 2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * b6sq, 16);
        x3 = sra(x1 + x2 + 2, 2);
        sum32 = longint'(x3 + C_B4_OFS) & 64'hFFFF_FFFF;
        b4 = (longint'(ac4) * sum32) >> 15;
        pr = 0;
        if (b4 == 0) begin
            fault = 1'b1;
        end else if (!fault) begin
            b7 = (longint'(up - b3) * C_B7_MUL) & 64'hFFFF_FFFF;
            if (b7 < 64'h8000_0000) p = (b7 * 2) / b4;
            else p = (b7 / b4) * 2;
            ps = longint'(p);
            q = ps >>> 8;
            x1 = sra(q * q * C_P_QUAD, 16);
            x2 = sra(C_P_LIN * ps, 16);
            pr = ps + sra(x1 + x2 + C_P_OFS, 4);
            if (pr < 0) pr = 0;
            if (pr > C_PRESS_MAX) pr = C_PRESS_MAX;
        end
        r.temperature_tenths = t[15:0];
        r.pressure_pa = fault ? 18'd0 : pr[17:0];
        r.math_fault = fault;
        return r;
    endfunction

    // driver: present the head of the queue, drop it on accept
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready_q) begin
                if (pending_items.size() > 0 && (calm_mode || $urandom_range(99) >= 34)) begin
                    i_in       <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && pending_items.size() > 0
                         && (calm_mode || $urandom_range(99) >= 34)) begin
                i_in       <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
            i_out_ready <= calm_mode || ($urandom_range(99) >= 34);
        end
    end

    // accept flags captured at the rising edge
    always @(posedge i_clk) begin
        o_in_ready_q <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_readings.push_back(compensate(i_in));
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: %p", o_out);
                error_count++;
            end else begin
                t_out_item e;
                e = expected_readings.pop_front();
                if (e.temperature_tenths !== o_out.temperature_tenths) begin
                    $error("temperature_tenths expected %0d actual %0d",
                           e.temperature_tenths, o_out.temperature_tenths);
                    error_count++;
                end
                if (e.pressure_pa !== o_out.pressure_pa) begin
                    $error("pressure_pa expected %0d actual %0d", e.pressure_pa,
                           o_out.pressure_pa);
                    error_count++;
                end
                if (e.math_fault !== o_out.math_fault) begin
                    $error("math_fault expected %0d actual %0d", e.math_fault,
                           o_out.math_fault);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (pending_items.size() == 0 && expected_readings.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("barometer_raw_compensation_core_test: done, errors");
                $finish;
            end
        end
    end

    task automatic write_cal(t_cfg_index idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CAL_A: cal_a = val;
            CFG_CAL_B: cal_b = val;
            default:   cal_c = val & 64'h0000_FFFF_FFFF_FFFF;
        endcase
    endtask

    task automatic wait_drained();
        wait (pending_items.size() == 0 && !i_in_valid);
        wait (expected_readings.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_reading();
        t_in_item it;
        it.raw_temperature = $urandom_range(99) < 70 ? 16'($urandom_range(20000, 35000))
                                                     : 16'($urandom);
        it.raw_pressure    = $urandom_range(99) < 70 ? 16'($urandom_range(20000, 45000))
                                                     : 16'($urandom);
        return it;
    endfunction

    task automatic push_reading(logic [15:0] ut, logic [15:0] up);
        t_in_item it;
        it.raw_temperature = ut;
        it.raw_pressure    = up;
        pending_items.push_back(it);
    endtask

    task automatic random_cal();
        // typical sensor coefficients with random spread, some fully random
        if ($urandom_range(3) == 0) begin
            write_cal(CFG_CAL_A, {$urandom, $urandom});
            write_cal(CFG_CAL_B, {$urandom, $urandom});
            write_cal(CFG_CAL_C, {$urandom, $urandom});
        end else begin
            write_cal(CFG_CAL_A, {16'($urandom_range(7000, 9000)),
                                  16'(-$urandom_range(800, 1500)),
                                  16'(-$urandom_range(13000, 15500)),
                                  16'($urandom_range(30000, 36000))});
            write_cal(CFG_CAL_B, {16'($urandom_range(23000, 27000)),
                                  16'($urandom_range(16000, 20000)),
                                  16'($urandom_range(5000, 7000)),
                                  16'($urandom_range(30, 60))});
            write_cal(CFG_CAL_C, {16'h0, 16'(-$urandom_range(32768)),
                                  16'(-$urandom_range(11786, 11786)),
                                  16'($urandom_range(2000, 3000))});
        end
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        calm_mode   = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_CAL_A;
        i_cfg_wdata = '0;
        cal_a = '0;
        cal_b = '0;
        cal_c = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-zero calibration: both divisors hit zero
        push_reading(16'h0000, 16'h0000);
        push_reading(16'hFFFF, 16'hFFFF);
        wait_drained();

        // datasheet example coefficients
        write_cal(CFG_CAL_A, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
        write_cal(CFG_CAL_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
        write_cal(CFG_CAL_C, {16'h8000, -16'sd8711, 16'd2868, 16'sd0} >> 16);
        write_cal(CFG_CAL_C, {16'h8000, -16'sd8711, 16'sd2868});
        push_reading(16'd27898, 16'd23843);
        push_reading(16'h0000, 16'h0000);
        push_reading(16'hFFFF, 16'hFFFF);
        push_reading(16'h0000, 16'hFFFF);
        push_reading(16'hFFFF, 16'h0000);
        push_reading(16'h8000, 16'h7FFF);
        push_reading(16'h5555, 16'hAAAA);
        push_reading(16'hAAAA, 16'h5555);
        wait_drained();

        // extreme calibration: all ones, then sign extremes
        write_cal(CFG_CAL_A, '1);
        write_cal(CFG_CAL_B, '1);
        write_cal(CFG_CAL_C, '1);
        push_reading(16'h0000, 16'h0000);
        push_reading(16'hFFFF, 16'hFFFF);
        push_reading(16'h1234, 16'hFEDC);
        wait_drained();
        write_cal(CFG_CAL_A, 64'h7FFF_8000_7FFF_FFFF);
        write_cal(CFG_CAL_B, 64'hFFFF_0000_8000_7FFF);
        write_cal(CFG_CAL_C, 64'h0000_7FFF_8000);
        push_reading(16'h0000, 16'h0000);
        push_reading(16'hFFFF, 16'hFFFF);
        push_reading(16'h8000, 16'h8000);
        wait_drained();
        // X1 = 0 with MD = 0 forces the temperature divisor to zero
        write_cal(CFG_CAL_C, 64'h0000_0000_1234_0000);
        write_cal(CFG_CAL_B, 64'h0000_0000_0000_0000);
        write_cal(CFG_CAL_A, 64'h1F90_FFB8_C7D1_7FE5);
        push_reading(16'd27898, 16'd23843);
        push_reading(16'hFFFF, 16'h0000);
        wait_drained();

        // random phases; one runs with no idling, each ends in a full pause
        for (int ph = 0; ph < 8; ph++) begin
            random_cal();
            calm_mode = (ph == 3);
            for (int k = 0; k < 225; k++)
                pending_items.push_back(rand_reading());
            wait_drained();
        end
        calm_mode = 1'b0;

        if (error_count == 0)
            $display("barometer_raw_compensation_core_test: done, clean");
        else
            $display("barometer_raw_compensation_core_test: done, errors");
        $finish;
    end
endmodule

/* files.f */
rtl/core/bcomp_pkg.sv
rtl/core/bcomp_udiv.sv
rtl/core/barometer_raw_compensation_core.sv
tb/barometer_raw_compensation_core_test.sv
